// ===== sv/gtn_pkg.sv =====
// ----------------------------------------------------------------------------
// gtn_pkg: shared types and constants for the grouped top-N score table
// Commands, status codes, sequencer states and the slot memory row.
// ----------------------------------------------------------------------------
package gtn_pkg;

  localparam int DEF_BOARD_DEPTH = 8;
  localparam int DEF_TABLE_SLOTS = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_LOW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] title;
    logic [31:0] board;
    logic [63:0] score;
    logic [63:0] stamp;
    logic [31:0] order;
  } slot_row_t;

endpackage

// ===== sv/gtn_if.sv =====
// ----------------------------------------------------------------------------
// gtn_req_if / gtn_rsp_if: request and result channels
// Valid/ready channels carrying one command beat or one result beat.
// ----------------------------------------------------------------------------
interface gtn_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] title_key;
  logic [31:0] board_id;
  logic [63:0] score_value;
  logic [63:0] time_stamp;

  modport source (output valid, command, title_key, board_id, score_value, time_stamp,
                  input ready);
  modport sink (input valid, command, title_key, board_id, score_value, time_stamp,
                output ready);
  modport monitor (input valid, ready, command, title_key, board_id, score_value,
                   time_stamp);
endinterface

interface gtn_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        entry_valid;
  logic [4:0]  rank;
  logic [63:0] entry_score;
  logic [63:0] entry_time;
  logic        last;

  modport source (output valid, status, entry_valid, rank, entry_score, entry_time, last,
                  input ready);
  modport sink (input valid, status, entry_valid, rank, entry_score, entry_time, last,
                output ready);
  modport monitor (input valid, ready, status, entry_valid, rank, entry_score, entry_time,
                   last);
endinterface

// ===== sv/gtn_slot_store.sv =====
// ----------------------------------------------------------------------------
// gtn_slot_store: slot memory
// One write port and one registered read port over the slot rows.
// ----------------------------------------------------------------------------
module gtn_slot_store
  import gtn_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int AW          = $clog2(TABLE_SLOTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_row_t     wdata,
  input  logic [AW-1:0] raddr,
  output slot_row_t     rdata
);

  slot_row_t mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/grouped_top_n_score_table_unit.sv =====
// ----------------------------------------------------------------------------
// grouped_top_n_score_table_unit: grouped top-N score table
// Keeps the best BOARD_DEPTH scores of each (title, board) group in a
// shared slot table, with insert, ranked read and clear commands.
// ----------------------------------------------------------------------------
// One command is handled at a time. Every insert and every ranked pass of a
// read walks the whole slot memory, one slot a cycle through its single read
// port: an insert gives its result beat after one pass, a read makes one pass
// per entry given (one pass for an empty group), and a clear or an unused
// command gives its result in the cycle after it is taken. The next command
// is taken once the last result beat has been accepted.
module grouped_top_n_score_table_unit
  import gtn_pkg::*;
#(
  parameter int BOARD_DEPTH = DEF_BOARD_DEPTH,
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic     clk,
  input  logic     rst,
  gtn_req_if.sink  req,
  gtn_rsp_if.source rsp
);

  localparam int AW   = $clog2(TABLE_SLOTS);
  localparam int IW   = AW + 1;
  localparam int CW   = $clog2(TABLE_SLOTS + 1);
  localparam int NW   = $clog2(BOARD_DEPTH + 1);
  localparam int CMPW = (CW > NW) ? CW + 1 : NW + 1;

  state_t state, state_next;

  logic [TABLE_SLOTS-1:0] slot_used;
  logic [31:0]            insert_counter;

  logic [1:0]  cmd;
  logic [31:0] title;
  logic [31:0] board;
  logic [63:0] score;
  logic [63:0] stamp;

  logic [IW-1:0] idx;
  logic          pend_v;
  logic [AW-1:0] pend_idx;

  logic          best_v;
  logic [AW-1:0] best_idx;
  logic [63:0]   best_score;
  logic [63:0]   best_time;
  logic [31:0]   best_order;
  logic [CW-1:0] held;
  logic          free_v;
  logic [AW-1:0] free_idx;

  logic [NW-1:0] n;
  logic [AW-1:0] prev_idx;
  logic [63:0]   prev_score;
  logic [31:0]   prev_order;

  logic [1:0]  o_status;
  logic        o_ev;
  logic [4:0]  o_rank;
  logic [63:0] o_score;
  logic [63:0] o_time;
  logic        o_last;

  slot_row_t rdata;
  slot_row_t wrow;
  logic      we;
  logic [AW-1:0] waddr;

  // true when key a ranks above key b
  function automatic logic above(input logic [63:0] as, input logic [31:0] ao,
                                 input logic [AW-1:0] ai, input logic [63:0] bs,
                                 input logic [31:0] bo, input logic [AW-1:0] bi);
    if (as != bs) return as > bs;
    if (ao != bo) return ao < bo;
    return ai < bi;
  endfunction

  gtn_slot_store #(.TABLE_SLOTS(TABLE_SLOTS), .AW(AW)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wrow),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  logic req_fire, rsp_fire, scan_done, cand_in, cand_ok, take, take_free;
  logic full_grp, ins_low, ins_none, read_last;

  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign scan_done = (idx == IW'(TABLE_SLOTS)) && !pend_v;
  assign cand_in   = pend_v && slot_used[pend_idx] && (rdata.title == title)
                     && (rdata.board == board);
  assign take_free = pend_v && !slot_used[pend_idx] && !free_v;
  assign full_grp  = held >= CW'(BOARD_DEPTH);
  assign ins_low   = full_grp && (score <= best_score);
  assign ins_none  = !full_grp && !free_v;
  assign read_last = (CMPW'(n) + CMPW'(1) == CMPW'(held))
                     || (CMPW'(n) + CMPW'(1) == CMPW'(BOARD_DEPTH));

  always_comb begin
    cand_ok = 1'b0;
    take    = 1'b0;
    if (cmd == CMD_READ) begin
      cand_ok = cand_in && ((n == '0)
                || above(prev_score, prev_order, prev_idx,
                         rdata.score, rdata.order, pend_idx));
      take = cand_ok && (!best_v || above(rdata.score, rdata.order, pend_idx,
                                          best_score, best_order, best_idx));
    end else begin
      // track the worst member: lowest score, newest on ties
      take = cand_in && (!best_v || above(best_score, best_order, best_idx,
                                          rdata.score, rdata.order, pend_idx));
    end
  end

  assign we    = (state == S_SCAN) && scan_done && (cmd == CMD_INSERT)
                 && !ins_low && !ins_none;
  assign waddr = full_grp ? best_idx : free_idx;
  assign wrow  = '{title: title, board: board, score: score, stamp: stamp,
                   order: insert_counter};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = (req.command == CMD_INSERT || req.command == CMD_READ)
                       ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        if (scan_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (rsp_fire) state_next = o_last ? S_IDLE : S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used      <= '0;
      insert_counter <= '0;
      pend_v         <= 1'b0;
    end else begin
      if (state == S_IDLE && req_fire) begin
        cmd      <= req.command;
        title    <= req.title_key;
        board    <= req.board_id;
        score    <= req.score_value;
        stamp    <= req.time_stamp;
        idx      <= '0;
        pend_v   <= 1'b0;
        best_v   <= 1'b0;
        held     <= '0;
        free_v   <= 1'b0;
        n        <= '0;
        o_status <= ST_DONE;
        o_ev     <= 1'b0;
        o_rank   <= '0;
        o_score  <= '0;
        o_time   <= '0;
        o_last   <= 1'b1;
        if (req.command == CMD_CLEAR) begin
          slot_used      <= '0;
          insert_counter <= '0;
        end
      end

      if (state == S_SCAN) begin
        // advance the read address and line the returned row up with its slot
        if (idx != IW'(TABLE_SLOTS)) begin
          idx      <= idx + IW'(1);
          pend_v   <= 1'b1;
          pend_idx <= idx[AW-1:0];
        end else begin
          pend_v <= 1'b0;
        end
        if (cand_in) held <= held + CW'(1);
        if (take) begin
          best_v     <= 1'b1;
          best_idx   <= pend_idx;
          best_score <= rdata.score;
          best_time  <= rdata.stamp;
          best_order <= rdata.order;
        end
        if (take_free) begin
          free_v   <= 1'b1;
          free_idx <= pend_idx;
        end
        if (scan_done) begin
          o_status <= ST_DONE;
          o_ev     <= 1'b0;
          o_rank   <= '0;
          o_score  <= '0;
          o_time   <= '0;
          o_last   <= 1'b1;
          if (cmd == CMD_INSERT) begin
            if (ins_low) begin
              o_status <= ST_LOW;
            end else if (ins_none) begin
              o_status <= ST_FULL;
            end else begin
              slot_used[waddr] <= 1'b1;
              insert_counter   <= insert_counter + 32'd1;
            end
          end else if (best_v) begin
            o_ev    <= 1'b1;
            o_rank  <= 5'(n);
            o_score <= best_score;
            o_time  <= best_time;
            o_last  <= read_last;
          end
        end
      end

      if (state == S_EMIT && rsp_fire && !o_last) begin
        // next ranked pass starts below the entry just given
        n          <= n + NW'(1);
        prev_idx   <= best_idx;
        prev_score <= best_score;
        prev_order <= best_order;
        idx        <= '0;
        pend_v     <= 1'b0;
        best_v     <= 1'b0;
        held       <= '0;
        free_v     <= 1'b0;
      end
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_EMIT);
  assign rsp.status      = o_status;
  assign rsp.entry_valid = o_ev;
  assign rsp.rank        = o_rank;
  assign rsp.entry_score = o_score;
  assign rsp.entry_time  = o_time;
  assign rsp.last        = o_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rsp.valid && req.ready))
    else $error("request taken while a result is pending");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.command == CMD_CLEAR) |=> (slot_used == '0 && insert_counter == '0))
    else $error("clear left slots in use");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.entry_valid) |-> rsp.last)
    else $error("result without entry not marked last");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    we |=> (state == S_EMIT && rsp.status == ST_DONE))
    else $error("slot write without placed status");
`endif

endmodule
